// ===== rtl/nsc_pkg.sv =====
// shared types and constants of the nmea sentence checker
package nsc_pkg;

  // line status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_FORMAT   = 2'd2;

  // sentence kind codes
  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_GGA   = 3'd1;
  localparam logic [2:0] KIND_GST   = 3'd2;
  localparam logic [2:0] KIND_HPR   = 3'd3;
  localparam logic [2:0] KIND_ZDA   = 3'd4;
  localparam logic [2:0] KIND_VTG   = 3'd5;
  localparam logic [2:0] KIND_ROT   = 3'd6;

  // characters
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_R      = "R";

  localparam logic [23:0] NAME_GGA = "GGA";
  localparam logic [23:0] NAME_GST = "GST";
  localparam logic [23:0] NAME_ZDA = "ZDA";
  localparam logic [23:0] NAME_VTG = "VTG";
  localparam logic [23:0] NAME_ROT = "ROT";
  localparam logic [23:0] NAME_AT  = {16'h4154, 8'h00};
  localparam logic [15:0] TALK_PS  = "PS";
  localparam logic [15:0] WIN_HP   = "HP";

  typedef struct packed {
    logic [1:0]  line_status;
    logic [2:0]  sentence_kind;
    logic [15:0] talker_id;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
  } res_t;

endpackage

// ===== rtl/nsc_in_if.sv =====
// byte input channel
interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/nsc_out_if.sv =====
// line result channel
interface nsc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  line_status;
  logic [2:0]  sentence_kind;
  logic [15:0] talker_id;
  logic [7:0]  computed_sum;
  logic [7:0]  received_sum;

  modport source (output valid, output line_status, output sentence_kind,
                  output talker_id, output computed_sum, output received_sum,
                  input ready);
  modport sink (input valid, input line_status, input sentence_kind,
                input talker_id, input computed_sum, input received_sum,
                output ready);
endinterface

// ===== rtl/nsc_parser.sv =====
// per-byte sentence parser with checksum and classification
module nsc_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  output logic              res_push,
  output nsc_pkg::res_t     res
);

  typedef enum logic [9:0] {
    PH_DOLLAR = 10'b0000000001,
    PH_TALK1  = 10'b0000000010,
    PH_TALK2  = 10'b0000000100,
    PH_NAME1  = 10'b0000001000,
    PH_NAME   = 10'b0000010000,
    PH_BODY   = 10'b0000100000,
    PH_HEX1   = 10'b0001000000,
    PH_HEX    = 10'b0010000000,
    PH_DONE   = 10'b0100000000,
    PH_FAIL   = 10'b1000000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] talk_r, talk_nxt;
  logic [23:0] name_r, name_nxt;
  logic [2:0]  nlen_r, nlen_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  hex_r, hex_nxt;
  logic        ovf_r, ovf_nxt;
  logic [15:0] win_r, win_nxt;
  logic        tag_r, tag_nxt;

  logic       is_alnum;
  logic       hex_ok;
  logic [3:0] hex_dig;
  logic [2:0] kind;

  always_comb begin
    is_alnum = (rx_byte >= "0" && rx_byte <= "9") || (rx_byte >= "A" && rx_byte <= "Z") ||
               (rx_byte >= "a" && rx_byte <= "z");
    hex_ok  = 1'b1;
    hex_dig = 4'd0;
    if (rx_byte >= "0" && rx_byte <= "9") begin
      hex_dig = rx_byte[3:0];
    end else if ((rx_byte >= "a" && rx_byte <= "f") || (rx_byte >= "A" && rx_byte <= "F")) begin
      // letters a-f and A-F share the low nibble 1..6
      hex_dig = rx_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    kind = nsc_pkg::KIND_OTHER;
    if (nlen_r == 3'd3 && name_r == nsc_pkg::NAME_GGA) begin
      kind = nsc_pkg::KIND_GGA;
    end else if (nlen_r == 3'd3 && name_r == nsc_pkg::NAME_GST) begin
      kind = nsc_pkg::KIND_GST;
    end else if (nlen_r == 3'd2 && talk_r == nsc_pkg::TALK_PS &&
                 name_r == nsc_pkg::NAME_AT) begin
      kind = tag_r ? nsc_pkg::KIND_HPR : nsc_pkg::KIND_OTHER;
    end else if (nlen_r == 3'd3 && name_r == nsc_pkg::NAME_ZDA) begin
      kind = nsc_pkg::KIND_ZDA;
    end else if (nlen_r == 3'd3 && name_r == nsc_pkg::NAME_VTG) begin
      kind = nsc_pkg::KIND_VTG;
    end else if (nlen_r == 3'd3 && name_r == nsc_pkg::NAME_ROT) begin
      kind = nsc_pkg::KIND_ROT;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    talk_nxt  = talk_r;
    name_nxt  = name_r;
    nlen_nxt  = nlen_r;
    xor_nxt   = xor_r;
    hex_nxt   = hex_r;
    ovf_nxt   = ovf_r;
    win_nxt   = win_r;
    tag_nxt   = tag_r;
    res       = '0;
    res.line_status = nsc_pkg::ST_FORMAT;
    res_push  = 1'b0;

    if (rx_byte == nsc_pkg::CH_LF) begin
      res_push = take;
      if (phase_r == PH_HEX || phase_r == PH_DONE) begin
        res.line_status   = (ovf_r || hex_r != xor_r) ? nsc_pkg::ST_MISMATCH
                                                      : nsc_pkg::ST_OK;
        res.sentence_kind = kind;
        res.talker_id     = talk_r;
        res.computed_sum  = xor_r;
        res.received_sum  = hex_r;
      end
      // every line starts from the reset state
      phase_nxt = PH_DOLLAR;
      talk_nxt  = '0;
      name_nxt  = '0;
      nlen_nxt  = '0;
      xor_nxt   = '0;
      hex_nxt   = '0;
      ovf_nxt   = 1'b0;
      win_nxt   = '0;
      tag_nxt   = 1'b0;
    end else begin
      case (phase_r)
        PH_DOLLAR: begin
          phase_nxt = (rx_byte == nsc_pkg::CH_DOLLAR) ? PH_TALK1 : PH_FAIL;
        end
        PH_TALK1: begin
          xor_nxt   = xor_r ^ rx_byte;
          talk_nxt  = {rx_byte, 8'h00};
          phase_nxt = PH_TALK2;
        end
        PH_TALK2: begin
          xor_nxt   = xor_r ^ rx_byte;
          talk_nxt  = {talk_r[15:8], rx_byte};
          phase_nxt = PH_NAME1;
        end
        PH_NAME1, PH_NAME: begin
          if (is_alnum) begin
            xor_nxt = xor_r ^ rx_byte;
            case (nlen_r)
              3'd0:    name_nxt = {rx_byte, name_r[15:0]};
              3'd1:    name_nxt = {name_r[23:16], rx_byte, name_r[7:0]};
              3'd2:    name_nxt = {name_r[23:8], rx_byte};
              default: name_nxt = name_r;
            endcase
            if (nlen_r < 3'd4) begin
              nlen_nxt = nlen_r + 3'd1;
            end
            phase_nxt = PH_NAME;
          end else if (rx_byte == nsc_pkg::CH_COMMA && phase_r == PH_NAME) begin
            xor_nxt   = xor_r ^ rx_byte;
            phase_nxt = PH_BODY;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_BODY: begin
          if (rx_byte == nsc_pkg::CH_STAR) begin
            phase_nxt = PH_HEX1;
          end else begin
            xor_nxt = xor_r ^ rx_byte;
            if (rx_byte == nsc_pkg::CH_R && win_r == nsc_pkg::WIN_HP) begin
              tag_nxt = 1'b1;
            end
            win_nxt = {win_r[7:0], rx_byte};
          end
        end
        PH_HEX1, PH_HEX: begin
          if (hex_ok) begin
            if (hex_r[7:4] != 4'd0) begin
              ovf_nxt = 1'b1;
            end
            hex_nxt   = {hex_r[3:0], hex_dig};
            phase_nxt = PH_HEX;
          end else begin
            phase_nxt = (phase_r == PH_HEX1) ? PH_FAIL : PH_DONE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DOLLAR;
      talk_r  <= '0;
      name_r  <= '0;
      nlen_r  <= '0;
      xor_r   <= '0;
      hex_r   <= '0;
      ovf_r   <= 1'b0;
      win_r   <= '0;
      tag_r   <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      talk_r  <= talk_nxt;
      name_r  <= name_nxt;
      nlen_r  <= nlen_nxt;
      xor_r   <= xor_nxt;
      hex_r   <= hex_nxt;
      ovf_r   <= ovf_nxt;
      win_r   <= win_nxt;
      tag_r   <= tag_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    nlen_r <= 3'd4)
    else $error("name length past saturation");

  a_name_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_NAME) |-> (nlen_r != 3'd0))
    else $error("name phase with no name characters");

  a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (take && rx_byte == nsc_pkg::CH_LF) |=> (phase_r == PH_DOLLAR && xor_r == 8'd0))
    else $error("parser state not cleared after line feed");
`endif

endmodule

// ===== rtl/nsc_out_reg.sv =====
// result register between the parser and the output channel
module nsc_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nsc_pkg::res_t din,
  output logic          can_take,
  nsc_out_if.source     out_ch
);

  logic          valid_r;
  nsc_pkg::res_t data_r;

  // a held result frees the register in the cycle it is taken
  assign can_take = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= din;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.line_status   = data_r.line_status;
  assign out_ch.sentence_kind = data_r.sentence_kind;
  assign out_ch.talker_id     = data_r.talker_id;
  assign out_ch.computed_sum  = data_r.computed_sum;
  assign out_ch.received_sum  = data_r.received_sum;

endmodule

// ===== rtl/nmea_sentence_check_classify.sv =====
// top level of the nmea sentence checker and classifier
//
// in_ch carries one received serial byte per transaction. A line feed byte
// ends the line, and each line gives exactly one transaction on out_ch with
// the line status, sentence kind, talker characters and both checksums.
// Other bytes give no result.
// Latency: the result of a line appears on out_ch in the cycle after its
// line feed is accepted. Throughput: one byte per cycle while in_ch.ready is
// high; the parser state is updated by one short step per byte and the
// result register is the only storage between the two channels.
// Reset (rst_n low, synchronous) returns the parser to waiting for a dollar
// sign and empties the result register.
// When the receiver stalls with a result held, in_ch.ready drops until that
// result is taken; in the cycle it is taken a new byte is accepted, so the
// input is held for as long as the stall lasts.
module nmea_sentence_check_classify (
  input  logic       clk,
  input  logic       rst_n,
  nsc_in_if.sink     in_ch,
  nsc_out_if.source  out_ch
);

  logic          take;
  logic          res_push;
  logic          can_take;
  nsc_pkg::res_t res;

  assign in_ch.ready = can_take;
  assign take        = in_ch.valid && can_take;

  nsc_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .rx_byte  (in_ch.rx_byte),
    .res_push (res_push),
    .res      (res)
  );

  nsc_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .din      (res),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_lf_result: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_ch.rx_byte == nsc_pkg::CH_LF) |=> out_ch.valid)
    else $error("line feed gave no result");

  a_format_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.line_status == nsc_pkg::ST_FORMAT) |->
      (out_ch.sentence_kind == nsc_pkg::KIND_OTHER && out_ch.talker_id == 16'd0 &&
       out_ch.computed_sum == 8'd0 && out_ch.received_sum == 8'd0))
    else $error("unrecognized line carries parsed fields");

  a_ok_sums: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.line_status == nsc_pkg::ST_OK) |->
      (out_ch.computed_sum == out_ch.received_sum))
    else $error("accepted line with differing checksums");
`endif

endmodule

// ===== tb/tb_nmea_sentence_check_classify.sv =====
// testbench of the nmea sentence checker: directed and random lines against a line predictor
`timescale 1ns / 100ps

module tb_nmea_sentence_check_classify;

  typedef enum logic [9:0] {
    P_DOLLAR = 10'b0000000001,
    P_TALK1  = 10'b0000000010,
    P_TALK2  = 10'b0000000100,
    P_NAME1  = 10'b0000001000,
    P_NAME   = 10'b0000010000,
    P_BODY   = 10'b0000100000,
    P_HEX1   = 10'b0001000000,
    P_HEX    = 10'b0010000000,
    P_DONE   = 10'b0100000000,
    P_FAIL   = 10'b1000000000
  } parse_phase_t;

  // how the checksum digits of a generated line are written
  typedef enum int {HX_PLAIN, HX_ONE, HX_PADDED, HX_WRONG, HX_WIDE, HX_NONE} hex_form_t;

  class sentence_scoreboard;
    parse_phase_t    phase;
    logic [15:0]     talker;
    logic [23:0]     name;
    int              name_len;
    logic [7:0]      xsum;
    logic [7:0]      hexv;
    bit              hex_ovf;
    logic [15:0]     window;
    bit              hpr_seen;
    nsc_pkg::res_t   pending_lines[$];
    int unsigned     fail_count;

    function new();
      fail_count = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase = P_DOLLAR;
      talker = '0;
      name = '0;
      name_len = 0;
      xsum = '0;
      hexv = '0;
      hex_ovf = 1'b0;
      window = '0;
      hpr_seen = 1'b0;
    endfunction

    function logic [2:0] kind_of_line();
      if (name_len == 3 && name == nsc_pkg::NAME_GGA) return nsc_pkg::KIND_GGA;
      if (name_len == 3 && name == nsc_pkg::NAME_GST) return nsc_pkg::KIND_GST;
      if (name_len == 2 && talker == nsc_pkg::TALK_PS && name == nsc_pkg::NAME_AT)
        return hpr_seen ? nsc_pkg::KIND_HPR : nsc_pkg::KIND_OTHER;
      if (name_len == 3 && name == nsc_pkg::NAME_ZDA) return nsc_pkg::KIND_ZDA;
      if (name_len == 3 && name == nsc_pkg::NAME_VTG) return nsc_pkg::KIND_VTG;
      if (name_len == 3 && name == nsc_pkg::NAME_ROT) return nsc_pkg::KIND_ROT;
      return nsc_pkg::KIND_OTHER;
    endfunction

    // advance the parse by one accepted byte; a line feed queues the line's result
    function void note_byte(logic [7:0] c);
      nsc_pkg::res_t r;
      int            dig;
      bit            alnum;
      if (c == nsc_pkg::CH_LF) begin
        r = '0;
        r.line_status = nsc_pkg::ST_FORMAT;
        if (phase == P_HEX || phase == P_DONE) begin
          r.line_status   = (hex_ovf || hexv != xsum) ? nsc_pkg::ST_MISMATCH : nsc_pkg::ST_OK;
          r.sentence_kind = kind_of_line();
          r.talker_id     = talker;
          r.computed_sum  = xsum;
          r.received_sum  = hexv;
        end
        pending_lines.push_back(r);
        clear_line();
        return;
      end
      alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      if (c >= "0" && c <= "9") dig = c - 8'h30;
      else if (c >= "a" && c <= "f") dig = c - 8'h57;
      else if (c >= "A" && c <= "F") dig = c - 8'h37;
      else dig = 16;
      case (phase)
        P_DOLLAR: begin
          if (c == nsc_pkg::CH_DOLLAR) phase = P_TALK1;
          else phase = P_FAIL;
        end
        P_TALK1: begin
          xsum ^= c;
          talker = {c, 8'h00};
          phase = P_TALK2;
        end
        P_TALK2: begin
          xsum ^= c;
          talker[7:0] = c;
          phase = P_NAME1;
        end
        P_NAME1, P_NAME: begin
          if (alnum) begin
            xsum ^= c;
            if (name_len < 3) name[8*(2-name_len) +: 8] = c;
            if (name_len < 4) name_len++;
            phase = P_NAME;
          end else if (c == nsc_pkg::CH_COMMA && phase == P_NAME) begin
            xsum ^= c;
            phase = P_BODY;
          end else begin
            phase = P_FAIL;
          end
        end
        P_BODY: begin
          if (c == nsc_pkg::CH_STAR) begin
            phase = P_HEX1;
          end else begin
            xsum ^= c;
            if (c == nsc_pkg::CH_R && window == nsc_pkg::WIN_HP) hpr_seen = 1'b1;
            window = {window[7:0], c};
          end
        end
        P_HEX1, P_HEX: begin
          if (dig < 16) begin
            if (hexv[7:4] != 4'd0) hex_ovf = 1'b1;
            hexv = {hexv[3:0], dig[3:0]};
            phase = P_HEX;
          end else if (phase == P_HEX1) begin
            phase = P_FAIL;
          end else begin
            phase = P_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        fail_count++;
      end
    endfunction

    function void check_line(nsc_pkg::res_t got);
      nsc_pkg::res_t want;
      if (pending_lines.size() == 0) begin
        $error("line result with no line pending");
        fail_count++;
        return;
      end
      want = pending_lines.pop_front();
      compare_field("line_status", want.line_status, got.line_status);
      compare_field("sentence_kind", want.sentence_kind, got.sentence_kind);
      compare_field("talker_id", want.talker_id, got.talker_id);
      compare_field("computed_sum", want.computed_sum, got.computed_sum);
      compare_field("received_sum", want.received_sum, got.received_sum);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  nsc_in_if  in_ch();
  nsc_out_if out_ch();

  nmea_sentence_check_classify dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sentence_scoreboard sb = new();

  int unsigned bytes_taken = 0;
  int unsigned bytes_sent = 0;
  int unsigned src_idle_pct = 24;
  int unsigned sink_idle_pct = 52;
  logic [7:0]  line_buf[$];

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_line({out_ch.line_status, out_ch.sentence_kind, out_ch.talker_id,
                       out_ch.computed_sum, out_ch.received_sum});
      if (in_ch.valid && in_ch.ready) begin
        sb.note_byte(in_ch.rx_byte);
        bytes_taken++;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b);
    int unsigned goal;
    goal = bytes_taken + 1;
    // idle pattern follows the number of bytes sent so far
    if (bytes_sent >= 300) begin
      src_idle_pct = 0;
      sink_idle_pct = 0;
    end else if (bytes_sent >= 150) begin
      src_idle_pct = 52;
      sink_idle_pct = 24;
    end
    bytes_sent++;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(negedge clk);
    while (bytes_taken < goal) @(negedge clk);
  endtask

  task automatic send_line();
    line_buf.push_back(nsc_pkg::CH_LF);
    foreach (line_buf[i]) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) return 8'h30 + d;
    return ($urandom_range(0, 1) ? 8'h57 : 8'h37) + d;
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == nsc_pkg::CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] body_byte();
    string      plain;
    logic [7:0] b;
    plain = ",.0123456789ABCDEHPRNSW-";
    if ($urandom_range(0, 99) < 70) return plain[$urandom_range(0, plain.len() - 1)];
    do b = 8'($urandom_range(0, 255)); while (b == nsc_pkg::CH_LF || b == nsc_pkg::CH_STAR);
    return b;
  endfunction

  // append the star and checksum digits for the sentence that starts at line_buf[0]
  function automatic void close_sentence(hex_form_t form);
    logic [7:0] s;
    s = '0;
    for (int i = 1; i < line_buf.size(); i++) s ^= line_buf[i];
    line_buf.push_back(nsc_pkg::CH_STAR);
    case (form)
      HX_PLAIN: ;
      HX_ONE: begin
        line_buf.push_back(hex_char(s[3:0]));
        return;
      end
      HX_PADDED: add_text("00");
      HX_WRONG: s ^= 8'($urandom_range(1, 255));
      HX_WIDE: line_buf.push_back(hex_char(4'($urandom_range(1, 15))));
      HX_NONE: return;
      default: ;
    endcase
    line_buf.push_back(hex_char(s[7:4]));
    line_buf.push_back(hex_char(s[3:0]));
  endfunction

  task automatic checked_line(string core, hex_form_t form);
    line_buf.push_back(nsc_pkg::CH_DOLLAR);
    add_text(core);
    close_sentence(form);
    add_text("\r");
    send_line();
  endtask

  task automatic directed_lines();
    checked_line("GPGGA,123519,4807.038,N,01131.000,E", HX_PLAIN);
    checked_line("GNGST,0.9,1.2", HX_PLAIN);
    checked_line("PSAT,HPR,12.3,4.5", HX_PLAIN);
    checked_line("PSAT,INTLT,1", HX_PLAIN);
    checked_line("GPZDA,201530.00,04,07,2002", HX_PLAIN);
    checked_line("GPVTG,054.7,T", HX_PLAIN);
    checked_line("GPROT,35.6,A", HX_PLAIN);
    checked_line("GPGGAX,1", HX_PLAIN);           // name too long
    checked_line("PSATX,HPR", HX_PLAIN);          // three-letter name under the PS talker
    checked_line("PSAT,H,PR", HX_PLAIN);          // split tag does not count
    checked_line("gpgga,2", HX_PLAIN);
    checked_line("GPGGA,1", HX_WRONG);
    checked_line("GPGST,2", HX_PADDED);           // leading zeros are harmless
    checked_line("GPZDA,3", HX_WIDE);             // nonzero digit overflows the byte
    checked_line("GPVTG,4", HX_NONE);             // no digit after the star
    checked_line("GPROT,5", HX_ONE);
    checked_line("GPGGA,7", HX_PLAIN);
    add_text("zz5\r");                            // stray bytes on a line of their own give a format result
    send_line();
    send_line();                                  // empty line
    add_text("x$GPGGA,5*00\r");                   // junk before the dollar sign
    send_line();
    add_text("$GP,1*00");                         // empty name
    send_line();
    add_text("$GPG");                             // cut short
    send_line();
    line_buf = '{nsc_pkg::CH_DOLLAR, 8'hFF, 8'h80};
    add_text("Z9a,");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'h7F);
    line_buf.push_back(8'hFF);
    close_sentence(HX_PLAIN);
    send_line();
    line_buf = '{nsc_pkg::CH_DOLLAR, 8'h00, 8'h00};
    add_text("A,HPR");
    close_sentence(HX_PLAIN);
    send_line();
  endtask

  function automatic void build_random_line();
    string alnum_set;
    string nm;
    int    r;
    int    n;
    int    k;
    int    tag_at;
    alnum_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    line_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      n = $urandom_range(0, 12);
      repeat (n) line_buf.push_back(rand_byte());
      return;
    end
    case ($urandom_range(0, 7))
      0: nm = "GGA";
      1: nm = "GST";
      2: nm = "ZDA";
      3: nm = "VTG";
      4: nm = "ROT";
      5, 6: nm = "AT";
      default: begin
        nm = "";
        n = $urandom_range(1, 5);
        repeat (n) nm = {nm, string'(alnum_set[$urandom_range(0, 61)])};
      end
    endcase
    line_buf.push_back(nsc_pkg::CH_DOLLAR);
    k = (nm == "AT" && $urandom_range(0, 99) < 80) ? 2 : $urandom_range(0, 3);
    case (k)
      0: add_text("GP");
      1: add_text("GN");
      2: add_text("PS");
      default: begin
        line_buf.push_back(rand_byte());
        line_buf.push_back(rand_byte());
      end
    endcase
    add_text(nm);
    line_buf.push_back(nsc_pkg::CH_COMMA);
    n = $urandom_range(0, 10);
    tag_at = $urandom_range(0, 1) ? $urandom_range(0, n) : -1;
    for (int i = 0; i <= n; i++) begin
      if (i == tag_at) add_text("HPR");
      if (i < n) line_buf.push_back(body_byte());
    end
    k = $urandom_range(0, 99);
    if (k < 65) close_sentence(HX_PLAIN);
    else if (k < 72) close_sentence(HX_ONE);
    else if (k < 80) close_sentence(HX_PADDED);
    else if (k < 88) close_sentence(HX_WRONG);
    else if (k < 95) close_sentence(HX_WIDE);
    else close_sentence(HX_NONE);
    k = $urandom_range(0, 99);
    if (k < 60) add_text("\r");
    else if (k < 75) add_text("G,1");
    // broken sequences: one byte damaged or the line cut short
    if (r < 25) begin
      line_buf[$urandom_range(0, line_buf.size() - 1)] = rand_byte();
    end else if (r < 30) begin
      k = $urandom_range(0, line_buf.size() - 1);
      while (line_buf.size() > k) void'(line_buf.pop_back());
    end
  endfunction

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_lines();

    while (bytes_sent < 450) begin
      build_random_line();
      send_line();
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_lines.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.fail_count == 0) begin
      $display("tb_nmea_sentence_check_classify passed");
    end else begin
      $display("tb_nmea_sentence_check_classify failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_nmea_sentence_check_classify failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nsc_pkg.sv
rtl/nsc_in_if.sv
rtl/nsc_out_if.sv
rtl/nsc_parser.sv
rtl/nsc_out_reg.sv
rtl/nmea_sentence_check_classify.sv
tb/tb_nmea_sentence_check_classify.sv
